[src/pcc_pkg.sv]
`default_nettype none

package pcc_pkg;

   localparam int POS_W       = 24;
   localparam int RAD_W       = 20;
   localparam int IDX_IN_W    = 12;
   localparam int GROUP_W     = 32;
   localparam int REPORT_W    = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int DIFF_W      = POS_W + 1;
   localparam int SQ_W        = 2 * POS_W + 1;
   localparam int SQ_SUM_W    = SQ_W + 2;
   localparam int RSUM_W      = RAD_W + 2;
   localparam int RSUM_SQ_W   = 2 * RSUM_W;

   localparam logic [1:0] REQ_TALLY = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic REG_SKIN  = 1'b0;
   localparam logic REG_GROUP = 1'b1;

   localparam logic [RAD_W-1:0]   SKIN_RESET  = '0;
   localparam logic [GROUP_W-1:0] GROUP_RESET = GROUP_W'(1);

   typedef logic signed [POS_W-1:0] pcc_pos_type;
   typedef logic [RAD_W-1:0]        pcc_rad_type;

   typedef struct packed {
      pcc_pos_type first_x;
      pcc_pos_type first_y;
      pcc_pos_type first_z;
      pcc_rad_type first_r;
      pcc_pos_type second_x;
      pcc_pos_type second_y;
      pcc_pos_type second_z;
      pcc_rad_type second_r;
   } pcc_pair_type;

   typedef struct packed {
      logic [RAD_W-1:0]   contact_skin;
      logic [GROUP_W-1:0] group_select;
   } pcc_cfg_type;

endpackage

`default_nettype wire

[src/pcc_csr.sv]
`default_nettype none

module pcc_csr
   import pcc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      pcc_cfg_type           cfg
);

   pcc_cfg_type cfg_ff;
   pcc_cfg_type cfg_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_SKIN:  cfg_in.contact_skin = csr_pwdata[RAD_W-1:0];
            REG_GROUP: cfg_in.group_select = csr_pwdata[GROUP_W-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.contact_skin <= SKIN_RESET;
         cfg_ff.group_select <= GROUP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SKIN:  csr_prdata = CSR_DATA_W'(cfg_ff.contact_skin);
         REG_GROUP: csr_prdata = CSR_DATA_W'(cfg_ff.group_select);
         default:   csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[src/pcc_geom.sv]
`default_nettype none

module pcc_geom
   import pcc_pkg::*;
(
   input  wire logic             clock,
   input  wire pcc_pair_type     pair,
   input  wire logic [RAD_W-1:0] contact_skin,
   output      logic             in_reach
);

   logic signed [DIFF_W-1:0]   dx;
   logic signed [DIFF_W-1:0]   dy;
   logic signed [DIFF_W-1:0]   dz;
   logic signed [2*DIFF_W-1:0] px;
   logic signed [2*DIFF_W-1:0] py;
   logic signed [2*DIFF_W-1:0] pz;
   logic [RSUM_W-1:0]          rsum;
   logic [SQ_W-1:0]            sq_x_in, sq_y_in, sq_z_in;
   logic [SQ_W-1:0]            sq_x_ff, sq_y_ff, sq_z_ff;
   logic [RSUM_SQ_W-1:0]       rsq_in, rsq_ff;
   logic [SQ_SUM_W-1:0]        total;
   logic                       in_reach_in, in_reach_ff;

   assign dx = {pair.first_x[POS_W-1], pair.first_x} - {pair.second_x[POS_W-1], pair.second_x};
   assign dy = {pair.first_y[POS_W-1], pair.first_y} - {pair.second_y[POS_W-1], pair.second_y};
   assign dz = {pair.first_z[POS_W-1], pair.first_z} - {pair.second_z[POS_W-1], pair.second_z};

   assign px = dx * dx;
   assign py = dy * dy;
   assign pz = dz * dz;

   assign sq_x_in = px[SQ_W-1:0];
   assign sq_y_in = py[SQ_W-1:0];
   assign sq_z_in = pz[SQ_W-1:0];

   assign rsum   = RSUM_W'(pair.first_r) + RSUM_W'(pair.second_r) + RSUM_W'(contact_skin);
   assign rsq_in = rsum * rsum;

   always_ff @(posedge clock) begin
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      sq_z_ff <= sq_z_in;
      rsq_ff  <= rsq_in;
   end

   assign total       = SQ_SUM_W'(sq_x_ff) + SQ_SUM_W'(sq_y_ff) + SQ_SUM_W'(sq_z_ff);
   assign in_reach_in = (total <= SQ_SUM_W'(rsq_ff));

   always_ff @(posedge clock) begin
      in_reach_ff <= in_reach_in;
   end

   assign in_reach = in_reach_ff;

endmodule

`default_nettype wire

[src/pcc_table.sv]
`default_nettype none

module pcc_table
   import pcc_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 16
)
(
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= store_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[src/pair_contact_counter_top.sv]
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_type, indices, positions, radii, groups
// rsp       out        rsp_valid/rsp_stall   rsp_count_value, rsp_contact_found, rsp_count_saturated
// csr       in/out     APB, pready always 1  contact_skin at 0x0, group_select at 0x4
//
// One transaction is worked on at a time through a single-port count memory.
// An overlapping tally makes two read-modify-write passes on the memory port, first index then
// second; a tally without contact only reads the first count, a read reads one count, a clear
// writes one zero, and a rejected request goes straight to the done state.
// After reset a clearing pass zeroes all PARTICLE_SLOTS words of the memory; no transaction is
// accepted until it ends, and configuration writes are taken as ever.
// A result waiting under rsp_stall does not block acceptance of the next request.
`default_nettype none

module pair_contact_counter_top
   import pcc_pkg::*;
#(
   parameter int PARTICLE_SLOTS = 4096,
   parameter int COUNT_BITS     = 16
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [1:0]            req_type,
   input  wire logic [IDX_IN_W-1:0]   req_first_index,
   input  wire logic [IDX_IN_W-1:0]   req_second_index,
   input  wire logic signed [POS_W-1:0] req_first_pos_x,
   input  wire logic signed [POS_W-1:0] req_first_pos_y,
   input  wire logic signed [POS_W-1:0] req_first_pos_z,
   input  wire logic [RAD_W-1:0]      req_first_radius,
   input  wire logic signed [POS_W-1:0] req_second_pos_x,
   input  wire logic signed [POS_W-1:0] req_second_pos_y,
   input  wire logic signed [POS_W-1:0] req_second_pos_z,
   input  wire logic [RAD_W-1:0]      req_second_radius,
   input  wire logic [GROUP_W-1:0]    req_owner_groups,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [REPORT_W-1:0]   rsp_count_value,
   output      logic                  rsp_contact_found,
   output      logic                  rsp_count_saturated,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   localparam int IDX_W   = $clog2(PARTICLE_SLOTS);
   localparam int RANGE_W = 17;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_MATH  = 8'b0000_0100,
      ST_CMP   = 8'b0000_1000,
      ST_WRI   = 8'b0001_0000,
      ST_RDJ   = 8'b0010_0000,
      ST_WRJ   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } pcc_state_type;

   function automatic logic [REPORT_W-1:0] report(input logic [COUNT_BITS-1:0] c);
      logic [31:0] wide;
      wide = 32'(c);
      if (wide > 32'(16'hFFFF)) begin
         report = 16'hFFFF;
      end else begin
         report = wide[REPORT_W-1:0];
      end
   endfunction

   pcc_cfg_type   cfg;
   pcc_pair_type  pair_in, pair_ff;
   pcc_state_type state_in, state_ff;

   logic [1:0]            type_ff;
   logic [IDX_IN_W-1:0]   idx_i_ff, idx_j_ff;
   logic                  gate_in, gate_ff;
   logic [COUNT_BITS-1:0] cnt_i_in, cnt_i_ff;
   logic                  sat_i_in, sat_i_ff;
   logic [IDX_W-1:0]      clr_in, clr_ff;

   logic [REPORT_W-1:0]   res_count_in, res_count_ff;
   logic                  res_found_in, res_found_ff;
   logic                  res_sat_in, res_sat_ff;
   logic [REPORT_W-1:0]   rsp_count_in, rsp_count_ff;
   logic                  rsp_found_in, rsp_found_ff;
   logic                  rsp_sat_in, rsp_sat_ff;
   logic                  rsp_valid_in, rsp_valid_ff;

   logic                  accept;
   logic                  i_ok, j_ok, type_ok;
   logic                  in_reach;
   logic                  mem_rd, mem_wr;
   logic [IDX_W-1:0]      mem_addr;
   logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;
   logic [COUNT_BITS-1:0] bump_val;
   logic                  bump_sat;
   logic                  out_free;

   pcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pcc_geom u_geom (
      .clock        (clock),
      .pair         (pair_ff),
      .contact_skin (cfg.contact_skin),
      .in_reach     (in_reach)
   );

   pcc_table #(
      .DEPTH (PARTICLE_SLOTS),
      .WIDTH (COUNT_BITS)
   ) u_table (
      .clock (clock),
      .rd_en (mem_rd),
      .wr_en (mem_wr),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign pair_in.first_x  = req_first_pos_x;
   assign pair_in.first_y  = req_first_pos_y;
   assign pair_in.first_z  = req_first_pos_z;
   assign pair_in.first_r  = req_first_radius;
   assign pair_in.second_x = req_second_pos_x;
   assign pair_in.second_y = req_second_pos_y;
   assign pair_in.second_z = req_second_pos_z;
   assign pair_in.second_r = req_second_radius;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign i_ok      = (RANGE_W'(req_first_index) < RANGE_W'(PARTICLE_SLOTS));
   assign j_ok      = (RANGE_W'(req_second_index) < RANGE_W'(PARTICLE_SLOTS));
   assign type_ok   = (req_type == REQ_TALLY) || (req_type == REQ_READ) ||
                      (req_type == REQ_CLEAR);
   assign gate_in   = j_ok & ((req_owner_groups & cfg.group_select) != '0);

   assign bump_sat  = (mem_rdata == '1);
   assign bump_val  = bump_sat ? mem_rdata : mem_rdata + COUNT_BITS'(1);
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cnt_i_in     = cnt_i_ff;
      sat_i_in     = sat_i_ff;
      res_count_in = res_count_ff;
      res_found_in = res_found_ff;
      res_sat_in   = res_sat_ff;
      rsp_count_in = rsp_count_ff;
      rsp_found_in = rsp_found_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      mem_rd       = 1'b0;
      mem_wr       = 1'b0;
      mem_addr     = IDX_W'(idx_i_ff);
      mem_wdata    = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(PARTICLE_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               res_count_in = '0;
               res_found_in = 1'b0;
               res_sat_in   = 1'b0;
               state_in     = (i_ok & type_ok) ? ST_MATH : ST_DONE;
            end
         end
         ST_MATH: begin
            if (type_ff == REQ_CLEAR) begin
               mem_wr   = 1'b1;
               state_in = ST_DONE;
            end else begin
               mem_rd   = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (type_ff == REQ_READ) begin
               res_count_in = report(mem_rdata);
               state_in     = ST_DONE;
            end else begin
               state_in = ST_WRI;
            end
         end
         ST_WRI: begin
            if (gate_ff & in_reach) begin
               mem_wr    = 1'b1;
               mem_wdata = bump_val;
               cnt_i_in  = bump_val;
               sat_i_in  = bump_sat;
               state_in  = ST_RDJ;
            end else begin
               res_count_in = report(mem_rdata);
               state_in     = ST_DONE;
            end
         end
         ST_RDJ: begin
            mem_rd   = 1'b1;
            mem_addr = IDX_W'(idx_j_ff);
            state_in = ST_WRJ;
         end
         ST_WRJ: begin
            mem_wr       = 1'b1;
            mem_addr     = IDX_W'(idx_j_ff);
            mem_wdata    = bump_val;
            res_count_in = report((idx_i_ff == idx_j_ff) ? bump_val : cnt_i_ff);
            res_found_in = 1'b1;
            res_sat_in   = sat_i_ff | bump_sat;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_count_in = res_count_ff;
               rsp_found_in = res_found_ff;
               rsp_sat_in   = res_sat_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_type;
         idx_i_ff <= req_first_index;
         idx_j_ff <= req_second_index;
         gate_ff  <= gate_in;
         pair_ff  <= pair_in;
      end
      cnt_i_ff     <= cnt_i_in;
      sat_i_ff     <= sat_i_in;
      res_count_ff <= res_count_in;
      res_found_ff <= res_found_in;
      res_sat_ff   <= res_sat_in;
      rsp_count_ff <= rsp_count_in;
      rsp_found_ff <= rsp_found_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_count_value     = rsp_count_ff;
   assign rsp_contact_found   = rsp_found_ff;
   assign rsp_count_saturated = rsp_sat_ff;

`ifndef NO_ASSERTIONS
   a_no_result_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("A result is pending during the clearing pass.");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("A result appeared without passing through the done state.");

   a_saturated_needs_contact: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |-> rsp_found_ff)
      else $error("Saturation reported without a contact.");

   a_contact_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_count_ff != '0))
      else $error("A contact was reported with a zero count.");
`endif

endmodule

`default_nettype wire
